/* design/tccs_pkg.sv */
// Package: shared constants, types and the sigmoid table of the conv/sigmoid unit.
package tccs_pkg;

	// Sizes of the image, the filters and the stores
	localparam int MAX_IMAGE  = 64;
	localparam int MAX_KERNEL = 5;
	localparam int IMG_W      = $clog2(MAX_IMAGE + 1);
	localparam int POS_W      = (MAX_IMAGE > 1) ? $clog2(MAX_IMAGE) : 1;
	localparam int KER_W      = $clog2(MAX_KERNEL + 1);
	localparam int KSEL_W     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int WN         = MAX_KERNEL * MAX_KERNEL;
	localparam int WSLOT_W    = (WN > 1) ? $clog2(WN) : 1;
	localparam int BIAS_DEPTH = MAX_IMAGE * MAX_IMAGE;
	localparam int BIAS_AW    = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;

	// Field widths of the channels
	localparam int MODE_W    = 2;
	localparam int SLOT_W    = 12;
	localparam int SAMPLE_W  = 16;
	localparam int OUT_POS_W = 6;
	localparam int ACT_W     = 16;

	// Configuration port
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH = 1'b1;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_WEIGHT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BIAS   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PIXEL  = 2'd2;

	// MAC datapath
	localparam int LANES  = 3 * WN;
	localparam int PROD_W = 2 * SAMPLE_W;
	localparam int ACC_W  = PROD_W + $clog2(LANES + 1) + 1;
	localparam int GRP    = 5;
	localparam int L1N    = (LANES + GRP - 1) / GRP;
	localparam int L2N    = (L1N + GRP - 1) / GRP;

	// Queues
	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = 2;
	localparam int OQ_DEPTH = 16;
	localparam int OQ_AW    = 4;

	typedef enum logic [1:0] {
		KIND_WEIGHT,
		KIND_BIAS,
		KIND_PIXEL
	} tccs_kind_t;

	// Three channel samples, channel one in element 0
	typedef logic [2:0][SAMPLE_W-1:0] tccs_px_t;
	typedef tccs_px_t [MAX_KERNEL-1:0][MAX_KERNEL-1:0] tccs_win_t;

	// Classified item between front and back
	typedef struct packed {
		tccs_kind_t           kind;
		logic [BIAS_AW-1:0]   addr;
		logic [WSLOT_W-1:0]   wslot;
		tccs_px_t             px;
		logic [POS_W-1:0]     col;
		logic [KSEL_W-1:0]    slot_row;
		logic [KSEL_W-1:0]    base;
		logic                 produce;
		logic                 final_res;
		logic [OUT_POS_W-1:0] out_row;
		logic [OUT_POS_W-1:0] out_col;
	} tccs_item_t;

	// Item leaving the window stage
	typedef struct packed {
		logic                 valid;
		tccs_kind_t           kind;
		logic [WSLOT_W-1:0]   wslot;
		tccs_px_t             px;
		logic                 produce;
		logic                 final_res;
		logic [OUT_POS_W-1:0] out_row;
		logic [OUT_POS_W-1:0] out_col;
		logic [SAMPLE_W-1:0]  bias;
	} tccs_stage_t;

	// Result entry of the output queue
	typedef struct packed {
		logic [OUT_POS_W-1:0] out_row;
		logic [OUT_POS_W-1:0] out_col;
		logic [ACT_W-1:0]     activation;
		logic                 final_res;
	} tccs_res_t;

	// Sigmoid sample points, step 0.5 from -8 to +8, Q0.16
	function automatic logic [15:0] sig_point(input logic [5:0] idx);
		logic [15:0] v;
		case (idx)
			6'd0:  v = 16'd22;
			6'd1:  v = 16'd36;
			6'd2:  v = 16'd60;
			6'd3:  v = 16'd98;
			6'd4:  v = 16'd162;
			6'd5:  v = 16'd267;
			6'd6:  v = 16'd439;
			6'd7:  v = 16'd720;
			6'd8:  v = 16'd1179;
			6'd9:  v = 16'd1921;
			6'd10: v = 16'd3108;
			6'd11: v = 16'd4971;
			6'd12: v = 16'd7812;
			6'd13: v = 16'd11955;
			6'd14: v = 16'd17625;
			6'd15: v = 16'd24743;
			6'd16: v = 16'd32768;
			6'd17: v = 16'd40793;
			6'd18: v = 16'd47911;
			6'd19: v = 16'd53581;
			6'd20: v = 16'd57724;
			6'd21: v = 16'd60565;
			6'd22: v = 16'd62428;
			6'd23: v = 16'd63615;
			6'd24: v = 16'd64357;
			6'd25: v = 16'd64816;
			6'd26: v = 16'd65097;
			6'd27: v = 16'd65269;
			6'd28: v = 16'd65374;
			6'd29: v = 16'd65438;
			6'd30: v = 16'd65476;
			6'd31: v = 16'd65500;
			default: v = 16'd65514;
		endcase
		return v;
	endfunction

endpackage

/* design/tccs_if.sv */
// Interfaces: input item channel and result channel.
interface tccs_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [tccs_pkg::MODE_W-1:0]          mode;
	logic [tccs_pkg::SLOT_W-1:0]          slot;
	logic signed [tccs_pkg::SAMPLE_W-1:0] sample_a;
	logic signed [tccs_pkg::SAMPLE_W-1:0] sample_b;
	logic signed [tccs_pkg::SAMPLE_W-1:0] sample_c;

	modport source (output valid, output mode, output slot, output sample_a,
		output sample_b, output sample_c, input ready);
	modport sink (input valid, input mode, input slot, input sample_a,
		input sample_b, input sample_c, output ready);
endinterface

interface tccs_out_if;
	logic                           valid;
	logic                           ready;
	logic [tccs_pkg::OUT_POS_W-1:0] out_row;
	logic [tccs_pkg::OUT_POS_W-1:0] out_col;
	logic [tccs_pkg::ACT_W-1:0]     activation;
	logic                           final_res;

	modport source (output valid, output out_row, output out_col, output activation,
		output final_res, input ready);
	modport sink (input valid, input out_row, input out_col, input activation,
		input final_res, output ready);
endinterface

/* design/tccs_front.sv */
// Front: config registers, item classification, raster position and the item queue.
module tccs_front (
	input  logic                                clk,
	input  logic                                arst_n,
	tccs_in_if.sink                             items,
	input  logic                                cfg_we,
	input  logic [tccs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tccs_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic [tccs_pkg::KER_W-1:0]          k_eff,
	output logic                                q_valid,
	output tccs_pkg::tccs_item_t                q_item,
	input  logic                                q_pop
);

	logic [6:0]                        image_width_q;
	logic [2:0]                        kernel_width_q;
	logic [tccs_pkg::POS_W-1:0]        row_q, col_q;
	logic [tccs_pkg::KSEL_W-1:0]       srow_q;
	logic [tccs_pkg::BIAS_AW-1:0]      bidx_q;
	tccs_pkg::tccs_item_t              fq_q [tccs_pkg::FQ_DEPTH];
	logic [tccs_pkg::FQ_AW-1:0]        fq_wp_q, fq_rp_q;
	logic [tccs_pkg::FQ_AW:0]          fq_cnt_q;

	logic [tccs_pkg::IMG_W-1:0]        w_eff;
	logic                              last_col, last_row, produce, keep, accept, push;
	logic [tccs_pkg::KSEL_W+1:0]       bsum;
	tccs_pkg::tccs_item_t              item;

	// Clamp registers to their legal ranges
	always_comb begin
		if (image_width_q == '0)
			w_eff = tccs_pkg::IMG_W'(1);
		else if (int'(image_width_q) > tccs_pkg::MAX_IMAGE)
			w_eff = tccs_pkg::IMG_W'(tccs_pkg::MAX_IMAGE);
		else
			w_eff = tccs_pkg::IMG_W'(image_width_q);
		if (kernel_width_q == '0)
			k_eff = tccs_pkg::KER_W'(1);
		else if (int'(kernel_width_q) > tccs_pkg::MAX_KERNEL)
			k_eff = tccs_pkg::KER_W'(tccs_pkg::MAX_KERNEL);
		else
			k_eff = tccs_pkg::KER_W'(kernel_width_q);
	end

	// Window position of the current pixel
	always_comb begin
		last_col = (int'(col_q) + 1) >= int'(w_eff);
		last_row = (int'(row_q) + 1) >= int'(w_eff);
		produce  = (int'(k_eff) <= int'(w_eff)) && ((int'(row_q) + 1) >= int'(k_eff))
			&& ((int'(col_q) + 1) >= int'(k_eff));
		// row-buffer slot holding the top window row
		bsum = (tccs_pkg::KSEL_W+2)'(srow_q) + (tccs_pkg::KSEL_W+2)'(tccs_pkg::MAX_KERNEL + 1)
			- (tccs_pkg::KSEL_W+2)'(k_eff);
		if (bsum >= (tccs_pkg::KSEL_W+2)'(tccs_pkg::MAX_KERNEL))
			bsum = bsum - (tccs_pkg::KSEL_W+2)'(tccs_pkg::MAX_KERNEL);
	end

	// Classify the incoming item
	always_comb begin
		item           = '0;
		item.px        = {items.sample_c, items.sample_b, items.sample_a};
		item.wslot     = tccs_pkg::WSLOT_W'(items.slot);
		item.col       = col_q;
		item.slot_row  = srow_q;
		item.base      = tccs_pkg::KSEL_W'(bsum);
		item.out_row   = tccs_pkg::OUT_POS_W'(int'(row_q) + 1 - int'(k_eff));
		item.out_col   = tccs_pkg::OUT_POS_W'(int'(col_q) + 1 - int'(k_eff));
		item.final_res = last_col && last_row;
		item.addr      = bidx_q;
		keep           = 1'b0;
		case (items.mode)
			tccs_pkg::MODE_WEIGHT: begin
				item.kind = tccs_pkg::KIND_WEIGHT;
				keep      = int'(items.slot) < tccs_pkg::WN;
			end
			tccs_pkg::MODE_BIAS: begin
				item.kind = tccs_pkg::KIND_BIAS;
				item.addr = tccs_pkg::BIAS_AW'(items.slot);
				keep      = int'(items.slot) < tccs_pkg::BIAS_DEPTH;
			end
			tccs_pkg::MODE_PIXEL: begin
				item.kind    = tccs_pkg::KIND_PIXEL;
				item.produce = produce;
				keep         = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign items.ready = fq_cnt_q != (tccs_pkg::FQ_AW+1)'(tccs_pkg::FQ_DEPTH);
	assign accept      = items.valid && items.ready;
	assign push        = accept && keep;
	assign q_valid     = fq_cnt_q != '0;
	assign q_item      = fq_q[fq_rp_q];

	// Config registers and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 7'd8;
			kernel_width_q <= 3'd3;
			row_q          <= '0;
			col_q          <= '0;
			srow_q         <= '0;
			bidx_q         <= '0;
		end else if (cfg_we) begin
			if (cfg_index == tccs_pkg::CFG_IMAGE_WIDTH)
				image_width_q <= cfg_data[6:0];
			else
				kernel_width_q <= cfg_data[2:0];
			row_q  <= '0;
			col_q  <= '0;
			srow_q <= '0;
			bidx_q <= '0;
		end else if (accept && items.mode == tccs_pkg::MODE_PIXEL) begin
			if (last_col && last_row)
				bidx_q <= '0;
			else if (produce)
				bidx_q <= bidx_q + tccs_pkg::BIAS_AW'(1);
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q  <= '0;
					srow_q <= '0;
				end else begin
					row_q  <= row_q + tccs_pkg::POS_W'(1);
					srow_q <= (srow_q == tccs_pkg::KSEL_W'(tccs_pkg::MAX_KERNEL - 1)) ? '0
						: srow_q + tccs_pkg::KSEL_W'(1);
				end
			end else begin
				col_q <= col_q + tccs_pkg::POS_W'(1);
			end
		end
	end

	// Item queue toward the back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fq_wp_q  <= '0;
			fq_rp_q  <= '0;
			fq_cnt_q <= '0;
		end else begin
			if (push)
				fq_wp_q <= fq_wp_q + tccs_pkg::FQ_AW'(1);
			if (q_pop)
				fq_rp_q <= fq_rp_q + tccs_pkg::FQ_AW'(1);
			fq_cnt_q <= fq_cnt_q + (tccs_pkg::FQ_AW+1)'(push) - (tccs_pkg::FQ_AW+1)'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fq_q[fq_wp_q] <= item;
	end

endmodule

/* design/tccs_window.sv */
// Window stage: row buffers, bias memory and the KxK three-channel window.
module tccs_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [tccs_pkg::KER_W-1:0]  k_eff,
	input  logic                        q_valid,
	input  tccs_pkg::tccs_item_t        q_item,
	output logic                        q_pop,
	input  logic                        credit_ok,
	output logic                        take_credit,
	output tccs_pkg::tccs_stage_t       st_s2,
	output tccs_pkg::tccs_win_t         win_q
);

	logic                         v_s1;
	tccs_pkg::tccs_item_t         item_s1;
	tccs_pkg::tccs_px_t           rows_s1 [tccs_pkg::MAX_KERNEL];
	logic [tccs_pkg::SAMPLE_W-1:0] bias_s1;
	logic [tccs_pkg::SAMPLE_W-1:0] bias_mem [tccs_pkg::BIAS_DEPTH];
	tccs_pkg::tccs_px_t           colv [tccs_pkg::MAX_KERNEL];

	// A result-producing item needs a free output slot
	assign q_pop       = q_valid && (!q_item.produce || credit_ok);
	assign take_credit = q_pop && q_item.produce;

	// One row buffer per row slot; the current slot is bypassed in s2
	for (genvar s = 0; s < tccs_pkg::MAX_KERNEL; s++) begin : g_row
		tccs_pkg::tccs_px_t row_mem [tccs_pkg::MAX_IMAGE];
		always_ff @(posedge clk) begin
			if (q_pop && q_item.kind == tccs_pkg::KIND_PIXEL
					&& q_item.slot_row == tccs_pkg::KSEL_W'(s))
				row_mem[q_item.col] <= q_item.px;
			if (q_pop)
				rows_s1[s] <= row_mem[q_item.col];
		end
	end

	// Bias memory: written by bias loads, read for each pixel
	always_ff @(posedge clk) begin
		if (q_pop && q_item.kind == tccs_pkg::KIND_BIAS)
			bias_mem[q_item.addr] <= q_item.px[0];
		if (q_pop)
			bias_s1 <= bias_mem[q_item.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= q_pop;
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			item_s1 <= q_item;
	end

	// New window column, rotated so row 0 is the top window row
	always_comb begin
		for (int i = 0; i < tccs_pkg::MAX_KERNEL; i++) begin
			colv[i] = '0;
			for (int bb = 0; bb < tccs_pkg::MAX_KERNEL; bb++) begin
				if (item_s1.base == tccs_pkg::KSEL_W'(bb))
					colv[i] = (item_s1.slot_row == tccs_pkg::KSEL_W'((bb + i) % tccs_pkg::MAX_KERNEL))
						? item_s1.px : rows_s1[(bb + i) % tccs_pkg::MAX_KERNEL];
			end
		end
	end

	// Shift window left, new column enters at position K-1
	always_ff @(posedge clk) begin
		if (v_s1 && item_s1.kind == tccs_pkg::KIND_PIXEL) begin
			for (int i = 0; i < tccs_pkg::MAX_KERNEL; i++) begin
				for (int j = 0; j < tccs_pkg::MAX_KERNEL - 1; j++) begin
					if (tccs_pkg::KER_W'(j + 1) < k_eff)
						win_q[i][j] <= win_q[i][j + 1];
				end
				for (int j = 0; j < tccs_pkg::MAX_KERNEL; j++) begin
					if (tccs_pkg::KER_W'(j + 1) == k_eff)
						win_q[i][j] <= colv[i];
				end
			end
		end
	end

	// Hand the item to the MAC stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s2 <= '0;
		end else begin
			st_s2.valid     <= v_s1;
			st_s2.kind      <= item_s1.kind;
			st_s2.wslot     <= item_s1.wslot;
			st_s2.px        <= item_s1.px;
			st_s2.produce   <= item_s1.produce;
			st_s2.final_res <= item_s1.final_res;
			st_s2.out_row   <= item_s1.out_row;
			st_s2.out_col   <= item_s1.out_col;
			st_s2.bias      <= bias_s1;
		end
	end

endmodule

/* design/tccs_mac.sv */
// MAC back end: weights, product lanes, adder tree, saturation, sigmoid, output queue.
module tccs_mac (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [tccs_pkg::KER_W-1:0]  k_eff,
	input  tccs_pkg::tccs_stage_t       st_s2,
	input  tccs_pkg::tccs_win_t         win_q,
	input  logic                        take_credit,
	output logic                        credit_ok,
	tccs_out_if.source                  results
);

	localparam int LERP_W = 24;

	typedef struct packed {
		logic [tccs_pkg::OUT_POS_W-1:0] out_row;
		logic [tccs_pkg::OUT_POS_W-1:0] out_col;
		logic                           final_res;
		logic [tccs_pkg::SAMPLE_W-1:0]  bias;
	} meta_t;

	tccs_pkg::tccs_px_t                   wt_q [tccs_pkg::WN];
	tccs_pkg::tccs_px_t                   wl [tccs_pkg::MAX_KERNEL][tccs_pkg::MAX_KERNEL];
	logic                                 act_lane [tccs_pkg::MAX_KERNEL][tccs_pkg::MAX_KERNEL];
	logic signed [tccs_pkg::PROD_W-1:0]   prod_s3 [tccs_pkg::LANES];
	logic signed [tccs_pkg::ACC_W-1:0]    l1_d [tccs_pkg::L1N];
	logic signed [tccs_pkg::ACC_W-1:0]    l1_s4 [tccs_pkg::L1N];
	logic signed [tccs_pkg::ACC_W-1:0]    l2_d [tccs_pkg::L2N];
	logic signed [tccs_pkg::ACC_W-1:0]    l2_s5 [tccs_pkg::L2N];
	logic signed [tccs_pkg::ACC_W-1:0]    acc_d, acc_s6, rnd;
	logic signed [tccs_pkg::SAMPLE_W-1:0] x_d, x_s7;
	logic [15:0]                          u;
	logic [15:0]                          t0, t1, tk_s8;
	logic [12:0]                          dlt;
	logic [LERP_W-1:0]                    lerp_s8;
	logic                                 v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	meta_t                                m_s3, m_s4, m_s5, m_s6, m_s7, m_s8;
	tccs_pkg::tccs_res_t                  res_d;
	tccs_pkg::tccs_res_t                  oq_q [tccs_pkg::OQ_DEPTH];
	logic [tccs_pkg::OQ_AW-1:0]           oq_wp_q, oq_rp_q;
	logic [tccs_pkg::OQ_AW:0]             oq_cnt_q, pending_q;
	logic                                 out_xfer;

	// Weight loads take effect in order with the pixels ahead of them
	always_ff @(posedge clk) begin
		if (st_s2.valid && st_s2.kind == tccs_pkg::KIND_WEIGHT)
			wt_q[st_s2.wslot] <= st_s2.px;
	end

	// Weight of each lane: flat index row*K+col
	always_comb begin
		for (int i = 0; i < tccs_pkg::MAX_KERNEL; i++) begin
			for (int j = 0; j < tccs_pkg::MAX_KERNEL; j++) begin
				wl[i][j] = '0;
				act_lane[i][j] = (tccs_pkg::KER_W'(i) < k_eff) && (tccs_pkg::KER_W'(j) < k_eff);
				for (int kk = 1; kk <= tccs_pkg::MAX_KERNEL; kk++) begin
					if (k_eff == tccs_pkg::KER_W'(kk))
						wl[i][j] = wt_q[i * kk + j];
				end
			end
		end
	end

	// s3: one multiplier per lane
	always_ff @(posedge clk) begin
		for (int i = 0; i < tccs_pkg::MAX_KERNEL; i++) begin
			for (int j = 0; j < tccs_pkg::MAX_KERNEL; j++) begin
				for (int ch = 0; ch < 3; ch++) begin
					prod_s3[(i * tccs_pkg::MAX_KERNEL + j) * 3 + ch] <= act_lane[i][j]
						? $signed(win_q[i][j][ch]) * $signed(wl[i][j][ch])
						: $signed(tccs_pkg::PROD_W'(0));
				end
			end
		end
	end

	// s4 and s5: adder tree in groups
	always_comb begin
		for (int g = 0; g < tccs_pkg::L1N; g++) begin
			l1_d[g] = '0;
			for (int e = 0; e < tccs_pkg::GRP; e++) begin
				if (g * tccs_pkg::GRP + e < tccs_pkg::LANES)
					l1_d[g] = l1_d[g] + tccs_pkg::ACC_W'(prod_s3[g * tccs_pkg::GRP + e]);
			end
		end
		for (int g = 0; g < tccs_pkg::L2N; g++) begin
			l2_d[g] = '0;
			for (int e = 0; e < tccs_pkg::GRP; e++) begin
				if (g * tccs_pkg::GRP + e < tccs_pkg::L1N)
					l2_d[g] = l2_d[g] + l1_s4[g * tccs_pkg::GRP + e];
			end
		end
	end

	// s6: final sum plus bias scaled to Q8.24
	always_comb begin
		acc_d = tccs_pkg::ACC_W'($signed(m_s5.bias)) <<< 12;
		for (int g = 0; g < tccs_pkg::L2N; g++)
			acc_d = acc_d + l2_s5[g];
	end

	// s7: round half up to Q4.12 and saturate
	always_comb begin
		rnd = (acc_s6 + $signed(tccs_pkg::ACC_W'(2048))) >>> 12;
		if (rnd > $signed(tccs_pkg::ACC_W'(32767)))
			x_d = 16'sh7fff;
		else if (rnd < -$signed(tccs_pkg::ACC_W'(32768)))
			x_d = -16'sh8000;
		else
			x_d = rnd[15:0];
	end

	// s8: table point and interpolation product
	always_comb begin
		u   = {~x_s7[15], x_s7[14:0]};
		t0  = tccs_pkg::sig_point({1'b0, u[15:11]});
		t1  = tccs_pkg::sig_point({1'b0, u[15:11]} + 6'd1);
		dlt = 13'(t1 - t0);
	end

	always_ff @(posedge clk) begin
		l1_s4   <= l1_d;
		l2_s5   <= l2_d;
		acc_s6  <= acc_d;
		x_s7    <= x_d;
		tk_s8   <= t0;
		lerp_s8 <= LERP_W'(dlt) * LERP_W'(u[10:0]);
		m_s3    <= '{out_row: st_s2.out_row, out_col: st_s2.out_col,
			final_res: st_s2.final_res, bias: st_s2.bias};
		m_s4    <= m_s3;
		m_s5    <= m_s4;
		m_s6    <= m_s5;
		m_s7    <= m_s6;
		m_s8    <= m_s7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s3 <= st_s2.valid && st_s2.kind == tccs_pkg::KIND_PIXEL && st_s2.produce;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Result into the output queue
	always_comb begin
		res_d.out_row    = m_s8.out_row;
		res_d.out_col    = m_s8.out_col;
		res_d.final_res  = m_s8.final_res;
		res_d.activation = tk_s8 + 16'((lerp_s8 + LERP_W'(1024)) >> 11);
	end

	assign out_xfer           = results.valid && results.ready;
	assign results.valid      = oq_cnt_q != '0;
	assign results.out_row    = oq_q[oq_rp_q].out_row;
	assign results.out_col    = oq_q[oq_rp_q].out_col;
	assign results.activation = oq_q[oq_rp_q].activation;
	assign results.final_res  = oq_q[oq_rp_q].final_res;

	// Credits: results in flight plus results queued never exceed the queue depth
	assign credit_ok = pending_q < (tccs_pkg::OQ_AW+1)'(tccs_pkg::OQ_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wp_q   <= '0;
			oq_rp_q   <= '0;
			oq_cnt_q  <= '0;
			pending_q <= '0;
		end else begin
			if (v_s8)
				oq_wp_q <= oq_wp_q + tccs_pkg::OQ_AW'(1);
			if (out_xfer)
				oq_rp_q <= oq_rp_q + tccs_pkg::OQ_AW'(1);
			oq_cnt_q  <= oq_cnt_q + (tccs_pkg::OQ_AW+1)'(v_s8) - (tccs_pkg::OQ_AW+1)'(out_xfer);
			pending_q <= pending_q + (tccs_pkg::OQ_AW+1)'(take_credit)
				- (tccs_pkg::OQ_AW+1)'(out_xfer);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s8)
			oq_q[oq_wp_q] <= res_d;
	end

`ifndef NO_ASSERTIONS
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= (tccs_pkg::OQ_AW+1)'(tccs_pkg::OQ_DEPTH))
		else $error("credit count above queue depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> oq_cnt_q != (tccs_pkg::OQ_AW+1)'(tccs_pkg::OQ_DEPTH))
		else $error("result pushed into a full output queue");
	a_queued_le_pending: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q <= pending_q)
		else $error("queued results exceed credits taken");
`endif

endmodule

/* design/three_channel_conv_sigmoid_unit.sv */
// Top level of the three-channel convolution and sigmoid unit.
// Usage:
//   items   : input channel (valid/ready). mode 0 loads the three weights of
//             filter slot row*K+col, mode 1 loads a bias (sample_a), mode 2 is a
//             pixel triple in raster order. Mode 3 is taken and dropped.
//   results : one activation per pixel that completes a KxK window, with its
//             output row/column and final_res on the last one of an image.
//   cfg_*   : image_width (index 0) and kernel_width (index 1); a write restarts
//             the image at pixel (0,0). Write only while the unit is idle.
// Throughput: one item per cycle sustained while output credits remain. All
//   3*K*K products are formed in parallel lanes and summed by a registered tree.
// Path: from item transfer to result transfer an item passes the front queue,
//   window stage, multiply, two tree levels, bias add, rounding, sigmoid
//   interpolation and output queue.
// Reset: registers return to width 8 and kernel 3, the position to (0,0) and
//   all queues empty. Weight and bias memories hold no value until loaded.
// Stall: results wait in a 16-entry output queue; when it has no room left for
//   results in flight, the window stage holds and the front queue fills and
//   then drops ready.
module three_channel_conv_sigmoid_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	tccs_in_if.sink                           items,
	tccs_out_if.source                        results,
	input  logic                              cfg_we,
	input  logic [tccs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tccs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [tccs_pkg::KER_W-1:0] k_eff;
	logic                       q_valid, q_pop, credit_ok, take_credit;
	tccs_pkg::tccs_item_t       q_item;
	tccs_pkg::tccs_stage_t      st_s2;
	tccs_pkg::tccs_win_t        win_q;

	tccs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.k_eff     (k_eff),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	tccs_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.k_eff       (k_eff),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.credit_ok   (credit_ok),
		.take_credit (take_credit),
		.st_s2       (st_s2),
		.win_q       (win_q)
	);

	tccs_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.k_eff       (k_eff),
		.st_s2       (st_s2),
		.win_q       (win_q),
		.take_credit (take_credit),
		.credit_ok   (credit_ok),
		.results     (results)
	);

endmodule

/* bench/tb.sv */
// Self-checking bench for the three-channel convolution and sigmoid unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 30;
	localparam int ITEM_TARGET = 1050;

	typedef struct {
		logic [tccs_pkg::MODE_W-1:0]          mode;
		logic [tccs_pkg::SLOT_W-1:0]          slot;
		logic signed [tccs_pkg::SAMPLE_W-1:0] sa;
		logic signed [tccs_pkg::SAMPLE_W-1:0] sb;
		logic signed [tccs_pkg::SAMPLE_W-1:0] sc;
	} conv_item_t;

	// Sigmoid sample points, step 0.5 over [-8, 8], Q0.16
	localparam int SIG_PTS [33] = '{
		22, 36, 60, 98, 162, 267, 439, 720, 1179, 1921, 3108, 4971, 7812,
		11955, 17625, 24743, 32768, 40793, 47911, 53581, 57724, 60565, 62428,
		63615, 64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514};

	localparam logic [tccs_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [tccs_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tccs_pkg::CFG_DATA_W-1:0] cfg_data;

	tccs_in_if  items();
	tccs_out_if results();

	three_channel_conv_sigmoid_unit dut (
		.clk(clk), .arst_n(arst_n), .items(items.sink), .results(results.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data));

	// Shadow state of the unit
	logic [6:0] width_reg;
	logic [2:0] kernel_reg;
	logic signed [15:0] weight_mem [tccs_pkg::WN][3];
	logic signed [15:0] bias_mem [tccs_pkg::BIAS_DEPTH];
	logic signed [15:0] line_buf [tccs_pkg::MAX_KERNEL][tccs_pkg::MAX_IMAGE][3];
	int pix_row, pix_col;
	bit bias_loaded [tccs_pkg::BIAS_DEPTH];

	conv_item_t pending_items [$];
	tccs_pkg::tccs_res_t act_expected [$];
	conv_item_t driven_item;
	int n_queued, n_accepted, n_checked, n_errors, n_configs;
	longint cycles;

	function automatic int eff_width();
		if (width_reg < 1) return 1;
		if (width_reg > tccs_pkg::MAX_IMAGE) return tccs_pkg::MAX_IMAGE;
		return width_reg;
	endfunction

	function automatic int eff_kernel();
		if (kernel_reg < 1) return 1;
		if (kernel_reg > tccs_pkg::MAX_KERNEL) return tccs_pkg::MAX_KERNEL;
		return kernel_reg;
	endfunction

	function automatic logic [15:0] sigmoid_lookup(input int x);
		int u, seg, frac, d;
		u = x + 32768;
		seg = u >> 11;
		frac = u & 2047;
		d = SIG_PTS[seg+1] - SIG_PTS[seg];
		return 16'(SIG_PTS[seg] + ((d * frac + 1024) >> 11));
	endfunction

	// Apply one accepted item to the shadow state, queue its activation
	task automatic predict_activation(input conv_item_t it);
		int w, k, r, c, r0, c0, ow, br;
		longint acc, q;
		tccs_pkg::tccs_res_t res;
		w = eff_width();
		k = eff_kernel();
		case (it.mode)
			tccs_pkg::MODE_WEIGHT: begin
				if (it.slot < tccs_pkg::WN) begin
					weight_mem[it.slot][0] = it.sa;
					weight_mem[it.slot][1] = it.sb;
					weight_mem[it.slot][2] = it.sc;
				end
			end
			tccs_pkg::MODE_BIAS: bias_mem[it.slot] = it.sa;
			tccs_pkg::MODE_PIXEL: begin
				if (pix_row >= w || pix_col >= w) begin
					pix_row = 0;
					pix_col = 0;
				end
				r = pix_row;
				c = pix_col;
				line_buf[r % tccs_pkg::MAX_KERNEL][c][0] = it.sa;
				line_buf[r % tccs_pkg::MAX_KERNEL][c][1] = it.sb;
				line_buf[r % tccs_pkg::MAX_KERNEL][c][2] = it.sc;
				if (k <= w && r + 1 >= k && c + 1 >= k) begin
					r0 = r + 1 - k;
					c0 = c + 1 - k;
					ow = w - k + 1;
					acc = 0;
					for (int i = 0; i < k; i++) begin
						br = (r0 + i) % tccs_pkg::MAX_KERNEL;
						for (int j = 0; j < k; j++)
							for (int ch = 0; ch < 3; ch++)
								acc += longint'(line_buf[br][c0+j][ch])
									* longint'(weight_mem[i*k+j][ch]);
					end
					acc += longint'(bias_mem[r0*ow+c0]) * 4096;
					q = (acc + 2048) >>> 12;
					if (q > 32767) q = 32767;
					if (q < -32768) q = -32768;
					res.out_row = tccs_pkg::OUT_POS_W'(r0);
					res.out_col = tccs_pkg::OUT_POS_W'(c0);
					res.activation = sigmoid_lookup(int'(q));
					res.final_res = (r == w - 1 && c == w - 1);
					act_expected.push_back(res);
				end
				pix_col = c + 1;
				if (pix_col >= w) begin
					pix_col = 0;
					pix_row = (r + 1 >= w) ? 0 : r + 1;
				end
			end
			default: ;
		endcase
	endtask

	// Idle rates: sender/receiver 36/47, then 47/36, then none
	function automatic bit sender_gap();
		if (n_accepted < 350) return $urandom_range(99) < 36;
		if (n_accepted < 700) return $urandom_range(99) < 47;
		return 0;
	endfunction

	function automatic bit receiver_stall();
		if (n_accepted < 350) return $urandom_range(99) < 47;
		if (n_accepted < 700) return $urandom_range(99) < 36;
		return 0;
	endfunction

	// Clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Item driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items.valid <= 1'b0;
			items.mode <= '0;
			items.slot <= '0;
			items.sample_a <= '0;
			items.sample_b <= '0;
			items.sample_c <= '0;
		end else begin
			if (items.valid && items.ready) begin
				predict_activation(driven_item);
				n_accepted++;
			end
			if (!items.valid || items.ready) begin
				if (pending_items.size() > 0 && !sender_gap()) begin
					driven_item = pending_items.pop_front();
					items.valid <= 1'b1;
					items.mode <= driven_item.mode;
					items.slot <= driven_item.slot;
					items.sample_a <= driven_item.sa;
					items.sample_b <= driven_item.sb;
					items.sample_c <= driven_item.sc;
				end else begin
					items.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin
		tccs_pkg::tccs_res_t exp_res;
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				if (act_expected.size() == 0) begin
					$display("%0t: unexpected result row %0d col %0d act %0d final %0b",
						$time, results.out_row, results.out_col, results.activation,
						results.final_res);
					n_errors++;
				end else begin
					exp_res = act_expected.pop_front();
					n_checked++;
					if (results.out_row !== exp_res.out_row) begin
						$display("%0t: out_row expected %0d actual %0d", $time,
							exp_res.out_row, results.out_row);
						n_errors++;
					end
					if (results.out_col !== exp_res.out_col) begin
						$display("%0t: out_col expected %0d actual %0d", $time,
							exp_res.out_col, results.out_col);
						n_errors++;
					end
					if (results.activation !== exp_res.activation) begin
						$display("%0t: activation expected %0d actual %0d", $time,
							exp_res.activation, results.activation);
						n_errors++;
					end
					if (results.final_res !== exp_res.final_res) begin
						$display("%0t: final_res expected %0b actual %0b", $time,
							exp_res.final_res, results.final_res);
						n_errors++;
					end
				end
			end
			results.ready <= !receiver_stall();
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				act_expected.size());
			$display("[three_channel_conv_sigmoid_unit] ERROR");
			$finish;
		end
	end

	function automatic logic [15:0] rand_sample(input bit full);
		if (full) return 16'($urandom);
		return 16'($urandom_range(1024) - 512);
	endfunction

	task automatic push_item(input logic [tccs_pkg::MODE_W-1:0] mode, input int slot,
			input logic [15:0] a, input logic [15:0] b, input logic [15:0] c);
		conv_item_t it;
		it.mode = mode;
		it.slot = tccs_pkg::SLOT_W'(slot);
		it.sa = a;
		it.sb = b;
		it.sc = c;
		if (mode == tccs_pkg::MODE_BIAS) bias_loaded[slot] = 1;
		pending_items.push_back(it);
		n_queued++;
	endtask

	// Let everything in flight finish before touching registers
	task automatic wait_idle();
		while (pending_items.size() != 0 || items.valid || act_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic [6:0] wval, input logic [6:0] kval);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= tccs_pkg::CFG_IMAGE_WIDTH;
		cfg_data <= wval;
		@(posedge clk);
		cfg_index <= tccs_pkg::CFG_KERNEL_WIDTH;
		cfg_data <= kval;
		@(posedge clk);
		cfg_we <= 1'b0;
		width_reg = wval;
		kernel_reg = kval[2:0];
		pix_row = 0;
		pix_col = 0;
		n_configs++;
	endtask

	// Load the biases the next npix pixels will read, then stream the pixels
	// with occasional reloads and ignored items mixed in
	task automatic pixel_run(input int npix, input int wide_pct);
		int w, k, r, c, ow, sel;
		w = eff_width();
		k = eff_kernel();
		ow = w - k + 1;
		for (int p = 0; p < npix; p++) begin
			r = (p / w) % w;
			c = p % w;
			if (k <= w && r >= k - 1 && c >= k - 1 && !bias_loaded[(r-k+1)*ow + c-k+1])
				push_item(tccs_pkg::MODE_BIAS, (r-k+1)*ow + c-k+1,
					rand_sample($urandom_range(1)), 16'($urandom), 16'($urandom));
		end
		for (int p = 0; p < npix; p++) begin
			push_item(tccs_pkg::MODE_PIXEL, $urandom_range(4095),
				rand_sample($urandom_range(99) < wide_pct),
				rand_sample($urandom_range(99) < wide_pct),
				rand_sample($urandom_range(99) < wide_pct));
			if ($urandom_range(99) < 8) begin
				sel = $urandom_range(3);
				case (sel)
					0: push_item(tccs_pkg::MODE_WEIGHT, $urandom_range(tccs_pkg::WN - 1),
						rand_sample(0), rand_sample(0), rand_sample(0));
					1: push_item(tccs_pkg::MODE_BIAS, $urandom_range(4095), rand_sample(1),
						16'($urandom), 16'($urandom));
					2: push_item(tccs_pkg::MODE_WEIGHT, $urandom_range(4095, tccs_pkg::WN),
						16'($urandom), 16'($urandom), 16'($urandom));
					default: push_item(MODE_UNUSED, $urandom_range(4095), 16'($urandom),
						16'($urandom), 16'($urandom));
				endcase
			end
		end
	endtask

	// Stimulus
	initial begin
		int wr, kr;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		width_reg = 7'd8;
		kernel_reg = 3'd3;
		pix_row = 0;
		pix_col = 0;
		cycles = 0;
		for (int i = 0; i < tccs_pkg::MAX_KERNEL; i++)
			for (int j = 0; j < tccs_pkg::MAX_IMAGE; j++)
				for (int ch = 0; ch < 3; ch++)
					line_buf[i][j][ch] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extreme weights, extreme biases, ignored items, extreme pixels
		push_item(tccs_pkg::MODE_WEIGHT, 0, 16'h7fff, 16'h8000, 16'h0000);
		push_item(tccs_pkg::MODE_WEIGHT, 1, 16'hffff, 16'h7fff, 16'h8000);
		for (int s = 2; s < tccs_pkg::WN; s++)
			push_item(tccs_pkg::MODE_WEIGHT, s, rand_sample(0), rand_sample(0),
				rand_sample(0));
		push_item(tccs_pkg::MODE_BIAS, 0, 16'h7fff, 16'h0000, 16'h0000);
		push_item(tccs_pkg::MODE_BIAS, 1, 16'h8000, 16'hffff, 16'hffff);
		push_item(tccs_pkg::MODE_WEIGHT, 4095, 16'hffff, 16'hffff, 16'hffff);
		push_item(tccs_pkg::MODE_WEIGHT, tccs_pkg::WN, 16'h1234, 16'h5678, 16'h9abc);
		push_item(MODE_UNUSED, 4095, 16'h7fff, 16'h8000, 16'hffff);
		push_item(tccs_pkg::MODE_PIXEL, 0, 16'h7fff, 16'h8000, 16'h7fff);
		push_item(tccs_pkg::MODE_PIXEL, 4095, 16'h8000, 16'h7fff, 16'h8000);
		push_item(tccs_pkg::MODE_PIXEL, 0, 16'hffff, 16'h0000, 16'hffff);
		pixel_run(64 - 3 + 10, 50);

		// Registers below range, above range, filter larger than image, edge sizes
		write_config(7'd0, 7'd0);
		pixel_run(3, 100);
		write_config(7'd127, 7'd7);
		pixel_run(5 * 64 + 8, 30);
		write_config(7'd3, 7'd5);
		pixel_run(12, 50);
		write_config(7'd5, 7'd5);
		pixel_run(30, 20);
		write_config(7'd64, 7'd1);
		pixel_run(80, 50);
		write_config(7'd16, 7'd2);
		pixel_run(300, 30);

		// Random sizes, mostly small
		while (n_queued < ITEM_TARGET) begin
			wr = $urandom_range(12);
			kr = $urandom_range(7);
			write_config(7'(wr), 7'(kr));
			wr = eff_width();
			pixel_run(wr * wr + $urandom_range(wr * wr), $urandom_range(100));
		end

		wait_idle();
		$display("Covered %0d items over %0d register settings, %0d activations checked.",
			n_accepted, n_configs + 1, n_checked);
		if (n_errors == 0 && act_expected.size() == 0)
			$display("[three_channel_conv_sigmoid_unit] OK");
		else
			$display("[three_channel_conv_sigmoid_unit] ERROR");
		$finish;
	end
endmodule

/* files.f */
design/tccs_pkg.sv
design/tccs_if.sv
design/tccs_front.sv
design/tccs_window.sv
design/tccs_mac.sv
design/three_channel_conv_sigmoid_unit.sv
bench/tb.sv
